[sv/ordered_record_list_unit_defines.svh]
// Assertion macros for the ordered record list unit.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef ORDERED_RECORD_LIST_UNIT_DEFINES_SVH
`define ORDERED_RECORD_LIST_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as the trigger
`define ORL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger
`define ORL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/orl_pkg.sv]
// Shared constants, types and helper functions for the ordered record list unit.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package orl_pkg;

   // Record storage size
   localparam int CAPACITY = 32;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Field widths
   localparam int FUNC_W   = 3;
   localparam int CODE_W   = 32;
   localparam int AMOUNT_W = 40;
   localparam int STATUS_W = 3;
   localparam int RATE_W   = 16;
   localparam int PROD_W   = AMOUNT_W + RATE_W;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type COUNT_FULL = COUNT_W'(CAPACITY);
   localparam addr_type  ADDR_TOP   = ADDR_W'(CAPACITY - 1);

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RAISE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RATE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

   localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;

   // One result word as queued for the response channel
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [CODE_W-1:0] rec_code;
      logic [AMOUNT_W-1:0]      rec_amount;
      logic                     last;
   } rsp_word_type;

   // Tag that follows one entry read down the walk pipeline
   typedef struct packed {
      logic     valid;
      addr_type addr;
      logic     last;
   } walk_tag_type;

   // Ring buffer pointer step forwards, wrapping at the capacity
   function automatic addr_type addr_inc(input addr_type ptr);
      addr_type res;
      res = (ptr == ADDR_TOP) ? '0 : ptr + ADDR_W'(1);
      return res;
   endfunction

   // Ring buffer pointer step backwards, wrapping at the capacity
   function automatic addr_type addr_dec(input addr_type ptr);
      addr_type res;
      res = (ptr == '0) ? ADDR_TOP : ptr - ADDR_W'(1);
      return res;
   endfunction

endpackage

`default_nettype wire

[sv/orl_req_if.sv]
// Request channel of the ordered record list unit: valid/ready plus one request word.
// Depends on orl_pkg for field widths.
`default_nettype none

interface orl_req_if;
   logic                               valid;
   logic                               ready;
   logic [orl_pkg::FUNC_W-1:0]         func;
   logic signed [orl_pkg::CODE_W-1:0]  code;
   logic [orl_pkg::AMOUNT_W-1:0]       amount;

   modport source (output valid, func, code, amount, input ready);
   modport sink   (input valid, func, code, amount, output ready);
endinterface

`default_nettype wire

[sv/orl_rsp_if.sv]
// Response channel of the ordered record list unit: valid/ready plus one result word.
// Depends on orl_pkg for field widths.
`default_nettype none

interface orl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [orl_pkg::STATUS_W-1:0]       status;
   logic signed [orl_pkg::CODE_W-1:0]  rec_code;
   logic [orl_pkg::AMOUNT_W-1:0]       rec_amount;
   logic                               last;

   modport source (output valid, status, rec_code, rec_amount, last, input ready);
   modport sink   (input valid, status, rec_code, rec_amount, last, output ready);
endinterface

`default_nettype wire

[sv/orl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module orl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/orl_rsp_fifo.sv]
// Two-word result queue in front of the response channel.
// Depends on orl_pkg and orl_rsp_if.
`default_nettype none

module orl_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire orl_pkg::rsp_word_type push_word,
   output logic [1:0]                 fill,
   orl_rsp_if.source                  rsp_chan
);

   orl_pkg::rsp_word_type slot_ff [2];
   logic                  rd_ptr_ff, rd_ptr_in;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  pop;

   assign pop = (count_ff != 2'd0) && rsp_chan.ready;

   // Pointer and fill bookkeeping
   always_comb begin
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff;
      case ({push_valid, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots, no reset needed
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign fill                = count_ff;
   assign rsp_chan.valid      = (count_ff != 2'd0);
   assign rsp_chan.status     = slot_ff[rd_ptr_ff].status;
   assign rsp_chan.rec_code   = slot_ff[rd_ptr_ff].rec_code;
   assign rsp_chan.rec_amount = slot_ff[rd_ptr_ff].rec_amount;
   assign rsp_chan.last       = slot_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

[sv/orl_raise_unit.sv]
// Raise datapath: amount plus truncated amount*rate, saturated to 40 bits.
// One register stage after the multiplier. Depends on orl_pkg.
`default_nettype none

module orl_raise_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire orl_pkg::walk_tag_type             in_tag,
   input  wire logic [orl_pkg::AMOUNT_W-1:0]      in_amount,
   input  wire logic [orl_pkg::RATE_W-1:0]        rate,
   output orl_pkg::walk_tag_type                  out_tag,
   output logic [orl_pkg::AMOUNT_W-1:0]           out_amount
);

   orl_pkg::walk_tag_type               tag_ff;
   logic [orl_pkg::AMOUNT_W-1:0]        amount_ff;
   logic [orl_pkg::PROD_W-1:0]          product_ff, product_in;
   logic [orl_pkg::AMOUNT_W:0]          sum;

   // 40 x 16 multiply, registered
   assign product_in = orl_pkg::PROD_W'(in_amount) * orl_pkg::PROD_W'(rate);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      amount_ff  <= in_amount;
      product_ff <= product_in;
   end

   // Add the Q16-aligned increment, clamp on carry out
   assign sum = {1'b0, amount_ff}
              + {1'b0, product_ff[orl_pkg::PROD_W-1:orl_pkg::RATE_W]};
   assign out_amount = sum[orl_pkg::AMOUNT_W] ? orl_pkg::AMOUNT_MAX
                                              : sum[orl_pkg::AMOUNT_W-1:0];
   assign out_tag = tag_ff;

endmodule

`default_nettype wire

[sv/ordered_record_list_unit.sv]
// Ordered record list unit: bounded list of (code, amount) records in a ring buffer.
// Depends on orl_pkg, orl_req_if, orl_rsp_if, orl_ram, orl_rsp_fifo, orl_raise_unit
// and the assertion macros in ordered_record_list_unit_defines.svh.
//
// Usage: one request word per operation on req_chan (append, insert at head,
// remove by code, raise all amounts, read out). Results leave on rsp_chan, the
// final word of each request carrying last. Unused function codes give no result.
// req_chan.ready is high only while idle, from the cycle after the final word is queued.
// Append, insert and rejected ops need no walk; remove searches and closes up
// in one pass over the stored records.
// Remove and raise walk one entry per cycle, set by the single read port of the
// record RAMs; the raise datapath registers the product before write-back. Read
// out is paced by room in the result queue.
// A two-word result queue lets the next request in while results wait; a stalled
// receiver holds read out and, once the queue is full, any further result.
// Reset empties the list (count, head, tail) at once; no clearing pass is run.
`default_nettype none
`include "ordered_record_list_unit_defines.svh"

module ordered_record_list_unit (
   input  wire logic clock,
   input  wire logic reset,
   orl_req_if.sink   req_chan,
   orl_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_RAISE,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type                             state_ff, state_in;
   logic [orl_pkg::FUNC_W-1:0]            func_ff, func_in;
   logic signed [orl_pkg::CODE_W-1:0]     code_ff, code_in;
   logic [orl_pkg::AMOUNT_W-1:0]          amount_ff, amount_in;
   orl_pkg::addr_type                     head_ff, head_in;
   orl_pkg::addr_type                     tail_ff, tail_in;
   orl_pkg::count_type                    count_ff, count_in;
   orl_pkg::addr_type                     rd_ptr_ff, rd_ptr_in;
   orl_pkg::count_type                    issued_ff, issued_in;
   orl_pkg::walk_tag_type                 tag1_ff, tag1_in;
   logic                                  found_ff, found_in;
   orl_pkg::addr_type                     dst_ff, dst_in;
   logic [orl_pkg::STATUS_W-1:0]          status_ff, status_in;

   logic                                  req_accept;
   logic                                  walk_more;
   logic                                  issue_last;
   logic                                  issue;
   logic                                  read_room;
   logic                                  match;
   logic                                  code_wr_en;
   logic                                  amt_wr_en;
   orl_pkg::addr_type                     wr_addr;
   logic signed [orl_pkg::CODE_W-1:0]     wr_code;
   logic [orl_pkg::AMOUNT_W-1:0]          wr_amount;
   logic signed [orl_pkg::CODE_W-1:0]     rd_code;
   logic [orl_pkg::AMOUNT_W-1:0]          rd_amount;
   logic                                  push_valid;
   orl_pkg::rsp_word_type                 push_word;
   logic [1:0]                            fifo_count;
   orl_pkg::walk_tag_type                 rs_in_tag;
   orl_pkg::walk_tag_type                 rs_out_tag;
   logic [orl_pkg::AMOUNT_W-1:0]          rs_out_amount;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && (state_ff == ST_IDLE);

   // Walk issue conditions
   assign walk_more  = (issued_ff != count_ff);
   assign issue_last = (issued_ff == (count_ff - orl_pkg::COUNT_W'(1)));
   assign read_room  = (fifo_count == 2'd0) || ((fifo_count == 2'd1) && !tag1_ff.valid);
   assign match      = (rd_code == code_ff);

   // Record storage
   orl_ram #(
      .WIDTH (orl_pkg::CODE_W),
      .DEPTH (orl_pkg::CAPACITY)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_code),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_code)
   );

   orl_ram #(
      .WIDTH (orl_pkg::AMOUNT_W),
      .DEPTH (orl_pkg::CAPACITY)
   ) u_amount_ram (
      .clock   (clock),
      .wr_en   (amt_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_amount),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_amount)
   );

   // Raise datapath only sees entries of a raise walk
   always_comb begin
      rs_in_tag       = tag1_ff;
      rs_in_tag.valid = tag1_ff.valid && (state_ff == ST_RAISE);
   end

   orl_raise_unit u_raise (
      .clock      (clock),
      .reset      (reset),
      .in_tag     (rs_in_tag),
      .in_amount  (rd_amount),
      .rate       (amount_ff[orl_pkg::RATE_W-1:0]),
      .out_tag    (rs_out_tag),
      .out_amount (rs_out_amount)
   );

   orl_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .fill       (fifo_count),
      .rsp_chan   (rsp_chan)
   );

   // Sequencer next-state and datapath control
   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      code_in    = code_ff;
      amount_in  = amount_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      issued_in  = issued_ff;
      tag1_in    = '0;
      found_in   = found_ff;
      dst_in     = dst_ff;
      status_in  = status_ff;
      issue      = 1'b0;
      code_wr_en = 1'b0;
      amt_wr_en  = 1'b0;
      wr_addr    = tail_ff;
      wr_code    = code_ff;
      wr_amount  = amount_ff;
      push_valid = 1'b0;
      push_word  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in   = req_chan.func;
               code_in   = req_chan.code;
               amount_in = req_chan.amount;
               state_in  = ST_DECODE;
            end
         end

         ST_DECODE: begin
            rd_ptr_in = head_ff;
            issued_in = '0;
            found_in  = 1'b0;
            state_in  = ST_FINISH;
            case (func_ff)
               orl_pkg::FUNC_APPEND: begin
                  if (count_ff == orl_pkg::COUNT_FULL) begin
                     status_in = orl_pkg::STATUS_FULL;
                  end else begin
                     code_wr_en = 1'b1;
                     amt_wr_en  = 1'b1;
                     wr_addr    = tail_ff;
                     tail_in    = orl_pkg::addr_inc(tail_ff);
                     count_in   = count_ff + orl_pkg::COUNT_W'(1);
                     status_in  = orl_pkg::STATUS_DONE;
                  end
               end
               orl_pkg::FUNC_INSERT: begin
                  if (count_ff == orl_pkg::COUNT_FULL) begin
                     status_in = orl_pkg::STATUS_FULL;
                  end else begin
                     code_wr_en = 1'b1;
                     amt_wr_en  = 1'b1;
                     wr_addr    = orl_pkg::addr_dec(head_ff);
                     head_in    = orl_pkg::addr_dec(head_ff);
                     count_in   = count_ff + orl_pkg::COUNT_W'(1);
                     status_in  = orl_pkg::STATUS_DONE;
                  end
               end
               orl_pkg::FUNC_REMOVE: begin
                  if (count_ff == '0) begin
                     status_in = orl_pkg::STATUS_NOT_FOUND;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               orl_pkg::FUNC_RAISE: begin
                  if (count_ff == '0) begin
                     status_in = orl_pkg::STATUS_EMPTY;
                  end else if ((amount_ff == '0) ||
                               (amount_ff[orl_pkg::AMOUNT_W-1:orl_pkg::RATE_W] != '0)) begin
                     status_in = orl_pkg::STATUS_BAD_RATE;
                  end else begin
                     state_in = ST_RAISE;
                  end
               end
               orl_pkg::FUNC_READ: begin
                  if (count_ff == '0) begin
                     status_in = orl_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = ST_READ;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // Search from the head; after the match every later entry moves up one slot
         ST_SCAN: begin
            issue = walk_more;
            if (tag1_ff.valid) begin
               if (found_ff) begin
                  code_wr_en = 1'b1;
                  amt_wr_en  = 1'b1;
                  wr_addr    = dst_ff;
                  wr_code    = rd_code;
                  wr_amount  = rd_amount;
                  dst_in     = tag1_ff.addr;
               end else if (match) begin
                  found_in = 1'b1;
                  dst_in   = tag1_ff.addr;
               end
               if (tag1_ff.last) begin
                  state_in = ST_FINISH;
                  if (found_ff || match) begin
                     status_in = orl_pkg::STATUS_DONE;
                     count_in  = count_ff - orl_pkg::COUNT_W'(1);
                     tail_in   = orl_pkg::addr_dec(tail_ff);
                  end else begin
                     status_in = orl_pkg::STATUS_NOT_FOUND;
                  end
               end
            end
         end

         // Read, multiply, write back the amount of each entry
         ST_RAISE: begin
            issue = walk_more;
            if (rs_out_tag.valid) begin
               amt_wr_en = 1'b1;
               wr_addr   = rs_out_tag.addr;
               wr_amount = rs_out_amount;
               if (rs_out_tag.last) begin
                  status_in = orl_pkg::STATUS_DONE;
                  state_in  = ST_FINISH;
               end
            end
         end

         // Stream entries out, throttled by room in the result queue
         ST_READ: begin
            issue = walk_more && read_room;
            if (tag1_ff.valid) begin
               push_valid = 1'b1;
               push_word  = '{status:     orl_pkg::STATUS_DONE,
                              rec_code:   rd_code,
                              rec_amount: rd_amount,
                              last:       tag1_ff.last};
               if (tag1_ff.last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         // Single status word
         ST_FINISH: begin
            if (fifo_count != 2'd2) begin
               push_valid = 1'b1;
               push_word  = '{status:     status_ff,
                              rec_code:   '0,
                              rec_amount: '0,
                              last:       1'b1};
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Read issue for all walks
      if (issue) begin
         tag1_in   = '{valid: 1'b1, addr: rd_ptr_ff, last: issue_last};
         rd_ptr_in = orl_pkg::addr_inc(rd_ptr_ff);
         issued_in = issued_ff + orl_pkg::COUNT_W'(1);
      end
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         tag1_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         tag1_ff  <= tag1_in;
         found_ff <= found_in;
      end
   end

   // Request and walk payload registers
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      code_ff   <= code_in;
      amount_ff <= amount_in;
      rd_ptr_ff <= rd_ptr_in;
      issued_ff <= issued_in;
      dst_ff    <= dst_in;
      status_ff <= status_in;
   end

   // Checks
   `ORL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= orl_pkg::COUNT_FULL, "record count above capacity")
   `ORL_ASSERT_NOW(a_queue_room, push_valid, fifo_count != 2'd2, "result pushed into full queue")
   `ORL_ASSERT_NOW(a_walk_drained, state_ff == ST_IDLE, !tag1_ff.valid && !rs_out_tag.valid, "idle with entry in flight")
   `ORL_ASSERT_NEXT(a_count_hold, (state_ff != ST_DECODE) && (state_ff != ST_SCAN), $stable(count_ff), "record count changed outside decode or search")

endmodule

`default_nettype wire

[tb/sv/ordered_record_list_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for ordered_record_list_unit: random and directed list operations.
// Depends on orl_pkg, orl_req_if, orl_rsp_if and the unit itself with its own dependencies.

module ordered_record_list_unit_test;

   localparam int CLOCK_HALF = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQUESTS = 110;
   localparam int SETTLE_CYCLES = orl_pkg::CAPACITY + 8;

   localparam logic signed [orl_pkg::CODE_W-1:0] CODE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [orl_pkg::CODE_W-1:0] CODE_MIN = 32'sh8000_0000;
   localparam logic [orl_pkg::AMOUNT_W-1:0] RATE_ONE = 40'h00_0001_0000;
   localparam logic [orl_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [orl_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   // Mirror of the list contents and the words it is due to send
   class record_list_mirror;
      typedef struct {
         logic signed [orl_pkg::CODE_W-1:0] code;
         logic [orl_pkg::AMOUNT_W-1:0]      amount;
      } record_type;

      record_type            records[$];
      orl_pkg::rsp_word_type due_words[$];
      int failures;
      int checked;
      int full_rejects;

      function void push_word(logic [orl_pkg::STATUS_W-1:0] status,
                              logic signed [orl_pkg::CODE_W-1:0] code,
                              logic [orl_pkg::AMOUNT_W-1:0] amount, logic last);
         orl_pkg::rsp_word_type w;
         w.status     = status;
         w.rec_code   = code;
         w.rec_amount = amount;
         w.last       = last;
         due_words.push_back(w);
      endfunction

      // amount + floor(amount * rate / 2^16), clipped to the top of the range
      function logic [orl_pkg::AMOUNT_W-1:0] raised(logic [orl_pkg::AMOUNT_W-1:0] amount,
                                                   logic [orl_pkg::AMOUNT_W-1:0] rate);
         logic [orl_pkg::PROD_W-1:0] prod;
         logic [orl_pkg::AMOUNT_W:0] sum;
         prod = orl_pkg::PROD_W'(amount) * orl_pkg::PROD_W'(rate[orl_pkg::RATE_W-1:0]);
         sum  = {1'b0, amount} + {1'b0, prod[orl_pkg::PROD_W-1:orl_pkg::RATE_W]};
         if (sum[orl_pkg::AMOUNT_W]) return orl_pkg::AMOUNT_MAX;
         return sum[orl_pkg::AMOUNT_W-1:0];
      endfunction

      // Update the list for one accepted request and queue its result words
      function void apply_request(logic [orl_pkg::FUNC_W-1:0] func,
                                  logic signed [orl_pkg::CODE_W-1:0] code,
                                  logic [orl_pkg::AMOUNT_W-1:0] amount);
         record_type r;
         int hit;
         hit = -1;
         case (func)
            orl_pkg::FUNC_APPEND, orl_pkg::FUNC_INSERT: begin
               if (records.size() >= orl_pkg::CAPACITY) begin
                  full_rejects++;
                  push_word(orl_pkg::STATUS_FULL, '0, '0, 1'b1);
               end else begin
                  r.code   = code;
                  r.amount = amount;
                  if (func == orl_pkg::FUNC_APPEND) records.push_back(r);
                  else records.push_front(r);
                  push_word(orl_pkg::STATUS_DONE, '0, '0, 1'b1);
               end
            end
            orl_pkg::FUNC_REMOVE: begin
               // first match from the head only
               for (int i = 0; i < records.size(); i++) begin
                  if (hit < 0 && records[i].code == code) hit = i;
               end
               if (hit >= 0) begin
                  records.delete(hit);
                  push_word(orl_pkg::STATUS_DONE, '0, '0, 1'b1);
               end else begin
                  push_word(orl_pkg::STATUS_NOT_FOUND, '0, '0, 1'b1);
               end
            end
            orl_pkg::FUNC_RAISE: begin
               // empty list takes precedence over a bad rate
               if (records.size() == 0) push_word(orl_pkg::STATUS_EMPTY, '0, '0, 1'b1);
               else if (amount == '0 || amount >= RATE_ONE)
                  push_word(orl_pkg::STATUS_BAD_RATE, '0, '0, 1'b1);
               else begin
                  foreach (records[i]) records[i].amount = raised(records[i].amount, amount);
                  push_word(orl_pkg::STATUS_DONE, '0, '0, 1'b1);
               end
            end
            orl_pkg::FUNC_READ: begin
               if (records.size() == 0) push_word(orl_pkg::STATUS_EMPTY, '0, '0, 1'b1);
               else begin
                  foreach (records[i])
                     push_word(orl_pkg::STATUS_DONE, records[i].code, records[i].amount,
                               i == records.size() - 1);
               end
            end
            default: ;  // spare codes: ignored, no word
         endcase
      endfunction

      // Compare one received word with the oldest one due
      function void check_word(logic [orl_pkg::STATUS_W-1:0] status,
                               logic signed [orl_pkg::CODE_W-1:0] code,
                               logic [orl_pkg::AMOUNT_W-1:0] amount, logic last);
         orl_pkg::rsp_word_type want;
         checked++;
         if (due_words.size() == 0) begin
            $error("unexpected result word: status %0d code %0d amount 0x%0h last %0b",
                   status, code, amount, last);
            failures++;
            return;
         end
         want = due_words.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
         end
         if (code !== want.rec_code) begin
            $error("rec_code: expected %0d, got %0d", want.rec_code, code);
            failures++;
         end
         if (amount !== want.rec_amount) begin
            $error("rec_amount: expected 0x%0h, got 0x%0h", want.rec_amount, amount);
            failures++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   orl_req_if req_chan ();
   orl_rsp_if rsp_chan ();

   record_list_mirror mirror;
   int gap_pct;
   int stall_pct;
   int requests_sent;
   int cycle_count;

   ordered_record_list_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: check each accepted word, then choose whether to stall next cycle
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         mirror.check_word(rsp_chan.status, rsp_chan.rec_code, rsp_chan.rec_amount,
                           rsp_chan.last);
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic void set_idling(int phase);
      case (phase)
         1:       begin gap_pct = 65; stall_pct = 0;  end
         2:       begin gap_pct = 0;  stall_pct = 65; end
         3:       begin gap_pct = 29; stall_pct = 29; end
         default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
   endfunction

   // Half the time a small pool so that codes repeat and removes find matches
   function automatic logic signed [orl_pkg::CODE_W-1:0] rand_code();
      int pool;
      pool = $urandom_range(15);
      if ($urandom_range(1) == 0) return $urandom;
      return pool - 8;
   endfunction

   function automatic logic signed [orl_pkg::CODE_W-1:0] removal_code();
      if (mirror.records.size() != 0 && $urandom_range(3) != 0)
         return mirror.records[$urandom_range(mirror.records.size() - 1)].code;
      return rand_code();
   endfunction

   function automatic logic [orl_pkg::AMOUNT_W-1:0] rand_amount();
      logic [orl_pkg::AMOUNT_W-1:0] v;
      v = orl_pkg::AMOUNT_W'({$urandom, $urandom});
      case ($urandom_range(3))
         0:       ;
         1:       v = orl_pkg::AMOUNT_W'($urandom & 32'h00FF_FFFF);
         2:       v = orl_pkg::AMOUNT_W'($urandom_range(6553600));
         default: v = $urandom_range(1) ? orl_pkg::AMOUNT_MAX : '0;
      endcase
      return v;
   endfunction

   function automatic logic [orl_pkg::AMOUNT_W-1:0] rand_rate();
      logic [orl_pkg::AMOUNT_W-1:0] v;
      v = orl_pkg::AMOUNT_W'({$urandom, $urandom});
      if ($urandom_range(4) != 0) return orl_pkg::AMOUNT_W'($urandom_range(65535, 1));
      case ($urandom_range(2))
         0:       v = '0;
         1:       v = RATE_ONE;
         default: ;
      endcase
      return v;
   endfunction

   // Present one request word, with an optional idle gap first, and wait for it to go
   task automatic send_request(input logic [orl_pkg::FUNC_W-1:0] func,
                               input logic signed [orl_pkg::CODE_W-1:0] code,
                               input logic [orl_pkg::AMOUNT_W-1:0] amount);
      if ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_chan.valid  <= 1'b1;
      req_chan.func   <= func;
      req_chan.code   <= code;
      req_chan.amount <= amount;
      do @(posedge clock); while (!req_chan.ready);
      mirror.apply_request(func, code, amount);
      if (func <= orl_pkg::FUNC_READ) requests_sent++;
   endtask

   initial begin
      int target;
      int round;
      int pick;
      logic [orl_pkg::FUNC_W-1:0] func;

      mirror = new;
      cycle_count = 0;
      requests_sent = 0;
      reset = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.func   = orl_pkg::FUNC_APPEND;
      req_chan.code   = '0;
      req_chan.amount = '0;
      rsp_chan.ready  = 1'b0;
      set_idling(0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list cases, field extremes, rate limits, saturation, spare codes
      send_request(orl_pkg::FUNC_READ, '0, '0);
      send_request(orl_pkg::FUNC_RAISE, '0, 40'd100);
      send_request(orl_pkg::FUNC_REMOVE, '0, '0);
      send_request(orl_pkg::FUNC_APPEND, CODE_MAX, orl_pkg::AMOUNT_MAX);
      send_request(orl_pkg::FUNC_INSERT, CODE_MIN, '0);
      send_request(orl_pkg::FUNC_APPEND, -1, RATE_ONE);
      send_request(orl_pkg::FUNC_READ, '0, '0);
      send_request(orl_pkg::FUNC_RAISE, '0, '0);
      send_request(orl_pkg::FUNC_RAISE, '0, RATE_ONE);
      send_request(orl_pkg::FUNC_RAISE, '0, orl_pkg::AMOUNT_MAX);
      send_request(orl_pkg::FUNC_RAISE, '0, RATE_ONE - 1);
      send_request(orl_pkg::FUNC_RAISE, '0, 40'd1);
      send_request(orl_pkg::FUNC_READ, '0, '0);
      send_request(orl_pkg::FUNC_REMOVE, -1, '0);
      send_request(orl_pkg::FUNC_REMOVE, 32'sd12345, '0);
      send_request(orl_pkg::FUNC_REMOVE, CODE_MIN, '0);
      for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++)
         send_request(orl_pkg::FUNC_W'(f), CODE_MAX, orl_pkg::AMOUNT_MAX);
      send_request(orl_pkg::FUNC_READ, '0, '0);
      send_request(orl_pkg::FUNC_REMOVE, CODE_MAX, '0);
      send_request(orl_pkg::FUNC_READ, '0, '0);

      // Random rounds, idling pattern changing from round to round
      target = requests_sent + RANDOM_REQUESTS;
      round = 0;
      while (requests_sent < target) begin
         set_idling(round % 4);
         round++;
         case ($urandom_range(9))
            0, 1, 2: begin
               // fill to capacity, then push against the full list
               while (mirror.records.size() < orl_pkg::CAPACITY)
                  send_request($urandom_range(2) ? orl_pkg::FUNC_APPEND : orl_pkg::FUNC_INSERT,
                               rand_code(), rand_amount());
               repeat ($urandom_range(2, 1))
                  send_request($urandom_range(1) ? orl_pkg::FUNC_APPEND : orl_pkg::FUNC_INSERT,
                               rand_code(), rand_amount());
               if ($urandom_range(1))
                  send_request(orl_pkg::FUNC_READ, rand_code(), rand_amount());
            end
            3, 4: begin
               repeat ($urandom_range(10, 3))
                  send_request(orl_pkg::FUNC_REMOVE, removal_code(), rand_amount());
            end
            5, 6: begin
               send_request(orl_pkg::FUNC_RAISE, rand_code(), rand_rate());
               send_request(orl_pkg::FUNC_READ, rand_code(), rand_amount());
            end
            default: begin
               // loose mix, including the odd spare code
               repeat (6) begin
                  pick = $urandom_range(19);
                  if (pick < 5) func = orl_pkg::FUNC_APPEND;
                  else if (pick < 8) func = orl_pkg::FUNC_INSERT;
                  else if (pick < 11) func = orl_pkg::FUNC_REMOVE;
                  else if (pick < 14) func = orl_pkg::FUNC_RAISE;
                  else if (pick < 19) func = orl_pkg::FUNC_READ;
                  else func = orl_pkg::FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
                  case (func)
                     orl_pkg::FUNC_REMOVE: send_request(func, removal_code(), rand_amount());
                     orl_pkg::FUNC_RAISE:  send_request(func, rand_code(), rand_rate());
                     default:              send_request(func, rand_code(), rand_amount());
                  endcase
               end
            end
         endcase
      end
      req_chan.valid <= 1'b0;

      // Let outstanding words arrive, then allow for any late stray word
      while (mirror.due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d list operations accepted over %0d rounds, %0d result words checked",
               requests_sent, round, mirror.checked);
      $display("%0d writes refused on a full list", mirror.full_rejects);
      if (mirror.failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
